// File: rtl/core/signed_restoring_divider_macros.svh
// ----------------------------------------------------------------------------
// signed_restoring_divider_macros.svh
// Assertion macros shared by the divider RTL.
// ----------------------------------------------------------------------------
`ifndef SIGNED_RESTORING_DIVIDER_MACROS_SVH
`define SIGNED_RESTORING_DIVIDER_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SRD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/srd_pkg.sv
// ----------------------------------------------------------------------------
// srd_pkg
// Shared constants and types of the signed restoring divider.
// ----------------------------------------------------------------------------
package srd_pkg;

  localparam int DefaultWidth = 16;

  // sign and exception flags that ride along with each transaction
  typedef struct packed {
    logic neg_q;
    logic neg_r;
    logic dbz;
  } flags_t;

endpackage

// File: rtl/core/srd_cell.sv
// ----------------------------------------------------------------------------
// srd_cell
// One restoring division step with its own elastic pipeline register.
// ----------------------------------------------------------------------------
`include "signed_restoring_divider_macros.svh"

module srd_cell #(
  parameter int Width = srd_pkg::DefaultWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [Width-1:0]   rem_i,
  input  logic [Width-1:0]   aq_i,
  input  logic [Width-1:0]   bm_i,
  input  srd_pkg::flags_t    flags_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [Width-1:0]   rem_o,
  output logic [Width-1:0]   aq_o,
  output logic [Width-1:0]   bm_o,
  output srd_pkg::flags_t    flags_o
);

  logic               valid_q;
  logic [Width-1:0]   rem_q, rem_d;
  logic [Width-1:0]   aq_q, aq_d;
  logic [Width-1:0]   bm_q;
  srd_pkg::flags_t    flags_q;
  logic [Width-1:0]   shifted;
  logic [Width:0]     diff;
  logic               ge;
  logic               load;

  // shift in next dividend bit, trial subtract
  assign shifted = {rem_i[Width-2:0], aq_i[Width-1]};
  assign diff    = {1'b0, shifted} - {1'b0, bm_i};
  assign ge      = ~diff[Width];
  assign rem_d   = ge ? diff[Width-1:0] : shifted;
  assign aq_d    = {aq_i[Width-2:0], ge};

  assign in_stall_o = valid_q & out_stall_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q   <= rem_d;
      aq_q    <= aq_d;
      bm_q    <= bm_i;
      flags_q <= flags_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rem_o       = rem_q;
  assign aq_o        = aq_q;
  assign bm_o        = bm_q;
  assign flags_o     = flags_q;

  `SRD_ASSERT_IMP(a_rem_below_divisor, valid_q && !flags_q.dbz, rem_q < bm_q,
                  "partial remainder not below divisor")
  `SRD_ASSERT_NXT(a_hold_when_stalled, valid_q && out_stall_i, valid_q && $stable(aq_q),
                  "cell lost or changed a stalled transaction")

endmodule

// File: rtl/core/signed_restoring_divider.sv
// ----------------------------------------------------------------------------
// signed_restoring_divider
// Pipelined signed restoring divider, truncating toward zero.
// ----------------------------------------------------------------------------
// Accepts one transaction per cycle while in_stall_o is low and passes each
// through one operand register that forms the magnitudes, a chain of WIDTH
// cells that each resolve one quotient bit, and one output register that
// applies the signs. Every stage is elastic, so a stall only holds the stages
// that are full. A zero divisor gives divide_by_zero with zero quotient and
// remainder; most negative over minus one wraps to the most negative value.
// ----------------------------------------------------------------------------
`include "signed_restoring_divider_macros.svh"

module signed_restoring_divider #(
  parameter int WIDTH = srd_pkg::DefaultWidth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [WIDTH-1:0] dividend_i,
  input  logic signed [WIDTH-1:0] divisor_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [WIDTH-1:0] quotient_o,
  output logic signed [WIDTH-1:0] remainder_o,
  output logic                    divide_by_zero_o
);

  // operand stage
  logic               op_valid_q;
  logic               op_stall;
  logic [WIDTH-1:0]   am_q, bm_q;
  srd_pkg::flags_t    op_flags_q, op_flags_d;

  // cell chain, index 0 is the operand stage
  logic               c_valid [0:WIDTH];
  logic               c_stall [0:WIDTH];
  logic [WIDTH-1:0]   c_rem   [0:WIDTH];
  logic [WIDTH-1:0]   c_aq    [0:WIDTH];
  logic [WIDTH-1:0]   c_bm    [0:WIDTH];
  srd_pkg::flags_t    c_flags [0:WIDTH];

  // output stage
  logic               out_valid_q;
  logic               out_stall;
  logic [WIDTH-1:0]   quot_q, quot_d;
  logic [WIDTH-1:0]   rem_q, rem_d;
  logic               dbz_q;
  logic               neg_r_q;

  assign op_flags_d.neg_q = dividend_i[WIDTH-1] ^ divisor_i[WIDTH-1];
  assign op_flags_d.neg_r = dividend_i[WIDTH-1];
  assign op_flags_d.dbz   = (divisor_i == '0);

  assign op_stall   = op_valid_q & c_stall[0];
  assign in_stall_o = op_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q <= 1'b0;
    end else if (!op_stall) begin
      op_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !op_stall) begin
      am_q       <= dividend_i[WIDTH-1] ? (WIDTH'(0) - WIDTH'(dividend_i)) : WIDTH'(dividend_i);
      bm_q       <= divisor_i[WIDTH-1]  ? (WIDTH'(0) - WIDTH'(divisor_i))  : WIDTH'(divisor_i);
      op_flags_q <= op_flags_d;
    end
  end

  assign c_valid[0] = op_valid_q;
  assign c_rem[0]   = '0;
  assign c_aq[0]    = am_q;
  assign c_bm[0]    = bm_q;
  assign c_flags[0] = op_flags_q;

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    srd_cell #(
      .Width (WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (c_valid[i]),
      .in_stall_o  (c_stall[i]),
      .rem_i       (c_rem[i]),
      .aq_i        (c_aq[i]),
      .bm_i        (c_bm[i]),
      .flags_i     (c_flags[i]),
      .out_valid_o (c_valid[i+1]),
      .out_stall_i (c_stall[i+1]),
      .rem_o       (c_rem[i+1]),
      .aq_o        (c_aq[i+1]),
      .bm_o        (c_bm[i+1]),
      .flags_o     (c_flags[i+1])
    );
  end

  // sign correction into the output register
  assign out_stall      = out_valid_q & out_stall_i;
  assign c_stall[WIDTH] = out_stall;

  always_comb begin
    quot_d = c_flags[WIDTH].neg_q ? (WIDTH'(0) - c_aq[WIDTH]) : c_aq[WIDTH];
    rem_d  = c_flags[WIDTH].neg_r ? (WIDTH'(0) - c_rem[WIDTH]) : c_rem[WIDTH];
    if (c_flags[WIDTH].dbz) begin
      quot_d = '0;
      rem_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_stall) begin
      out_valid_q <= c_valid[WIDTH];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_valid[WIDTH] && !out_stall) begin
      quot_q  <= quot_d;
      rem_q   <= rem_d;
      dbz_q   <= c_flags[WIDTH].dbz;
      neg_r_q <= c_flags[WIDTH].neg_r;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign quotient_o       = quot_q;
  assign remainder_o      = rem_q;
  assign divide_by_zero_o = dbz_q;

  `SRD_ASSERT_IMP(a_dbz_zero, out_valid_q && dbz_q, quot_q == '0 && rem_q == '0,
                  "divide by zero result not zero")
  `SRD_ASSERT_IMP(a_rem_sign, out_valid_q && !dbz_q && !neg_r_q, !rem_q[WIDTH-1],
                  "remainder sign differs from dividend")
  `SRD_ASSERT_IMP(a_stall_full, in_stall_o, out_valid_q && out_stall_i,
                  "input stalled while output side is free")

endmodule

// File: tb/tb_signed_restoring_divider.sv
// ----------------------------------------------------------------------------
// tb_signed_restoring_divider
// Self-checking testbench for the pipelined signed restoring divider.
// ----------------------------------------------------------------------------
// A short directed set covers zero divisors, most negative operands, sign
// combinations and the wrapping quotient of most negative over minus one.
// After it comes a long run of random operand pairs. Both handshakes idle at
// random, apart from one stretch with no idling at all. Each accepted
// transaction is divided in the testbench by restoring division on the
// magnitudes. Each result is checked field by field against the oldest
// quotient still owed.
// ----------------------------------------------------------------------------
module tb_signed_restoring_divider;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = srd_pkg::DefaultWidth;
  localparam int RandomCount = 1850;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = W + 10;

  class quotient_ledger;
    typedef struct {
      logic signed [W-1:0] quotient;
      logic signed [W-1:0] remainder;
      logic                divide_by_zero;
    } division_t;

    division_t owed[$];
    int        failures = 0;

    static function division_t divide(logic [W-1:0] a, logic [W-1:0] b);
      division_t   d;
      logic        neg_a, neg_b;
      logic [W-1:0] mag_a, mag_b, q;
      logic [W:0]   r;
      d.divide_by_zero = 1'b0;
      if (b == '0) begin
        d.quotient = '0;
        d.remainder = '0;
        d.divide_by_zero = 1'b1;
        return d;
      end
      neg_a = a[W-1];
      neg_b = b[W-1];
      mag_a = neg_a ? -a : a;
      mag_b = neg_b ? -b : b;
      q = '0;
      r = '0;
      for (int i = W - 1; i >= 0; i--) begin
        r = {r[W-1:0], mag_a[i]};
        q = q << 1;
        if (r >= {1'b0, mag_b}) begin
          r = r - {1'b0, mag_b};
          q[0] = 1'b1;
        end
      end
      d.quotient = (neg_a != neg_b) ? -q : q;
      d.remainder = neg_a ? -r[W-1:0] : r[W-1:0];
      return d;
    endfunction

    function void note_operands(logic [W-1:0] a, logic [W-1:0] b);
      owed.push_back(divide(a, b));
    endfunction

    function void check_result(logic [W-1:0] q, logic [W-1:0] r, logic dbz);
      division_t d;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result q=%0h r=%0h dbz=%0b", $time, q, r, dbz);
        failures++;
        return;
      end
      d = owed.pop_front();
      if (q !== d.quotient) begin
        $display("%0t: quotient expected %0h actual %0h", $time, d.quotient, q);
        failures++;
      end
      if (r !== d.remainder) begin
        $display("%0t: remainder expected %0h actual %0h", $time, d.remainder, r);
        failures++;
      end
      if (dbz !== d.divide_by_zero) begin
        $display("%0t: divide_by_zero expected %0b actual %0b", $time, d.divide_by_zero,
                 dbz);
        failures++;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic signed [W-1:0] dividend_i = '0;
  logic signed [W-1:0] divisor_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic signed [W-1:0] quotient_o;
  logic signed [W-1:0] remainder_o;
  logic                divide_by_zero_o;

  quotient_ledger ledger = new();
  logic           steady = 1'b0;
  int             cycles = 0;

  signed_restoring_divider #(.WIDTH(W)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .dividend_i      (dividend_i),
    .divisor_i       (divisor_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .quotient_o      (quotient_o),
    .remainder_o     (remainder_o),
    .divide_by_zero_o(divide_by_zero_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // input monitor and output checker
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      ledger.note_operands(dividend_i, divisor_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      ledger.check_result(quotient_o, remainder_o, divide_by_zero_o);
  end

  always @(posedge clk_i) begin
    out_stall_i <= steady ? 1'b0 : ($urandom_range(99) < 33);
  end

  task automatic send_operands(int a, int b);
    if (!steady) begin
      while ($urandom_range(99) < 33) begin
        in_valid_i <= 1'b0;
        dividend_i <= W'($urandom);
        divisor_i <= W'($urandom);
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    dividend_i <= W'(a);
    divisor_i <= W'(b);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ledger.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [W-1:0] signed_small(int hi);
    logic [W-1:0] v;
    v = W'($urandom_range(hi, 1));
    return $urandom_range(1) ? -v : v;
  endfunction

  task automatic send_random();
    logic [W-1:0] a, b;
    a = W'($urandom);
    b = W'($urandom);
    case ($urandom_range(9))
      5: b = signed_small(20);
      6: b = ($urandom_range(3) == 0) ? '0 : signed_small(1);
      7: a = $urandom_range(1) ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      8: b = $urandom_range(1) ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      9: begin
        a = signed_small(200);
        b = signed_small(15);
      end
      default: ;
    endcase
    send_operands(int'(a), int'(b));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero divisors
    send_operands(5, 0);
    send_operands(-32768, 0);
    send_operands(32767, 0);
    send_operands(0, 0);
    send_operands(-1, 0);
    // most negative operands and the wrapping quotient
    send_operands(-32768, -1);
    send_operands(-32768, 1);
    send_operands(-32768, -32768);
    send_operands(-32768, 32767);
    send_operands(32767, -32768);
    send_operands(-32767, -32768);
    send_operands(1, -32768);
    send_operands(0, -32768);
    send_operands(32767, 32767);
    send_operands(32767, 1);
    send_operands(-32767, -1);
    // sign combinations
    send_operands(7, 2);
    send_operands(-7, 2);
    send_operands(7, -2);
    send_operands(-7, -2);
    send_operands(0, 5);
    send_operands(3, 7);
    send_operands(-3, 7);
    send_operands(-1, 1);
    send_operands(32'h5555, 32'h00aa);
    wait_for_results();

    for (int i = 0; i < RandomCount; i++) begin
      steady = (i >= 700 && i < 1000);
      if (i == 1300) wait_for_results();
      send_random();
    end
    steady = 1'b0;

    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (ledger.failures == 0 && ledger.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/srd_pkg.sv
rtl/core/srd_cell.sv
rtl/core/signed_restoring_divider.sv
tb/tb_signed_restoring_divider.sv
